// ===== design/adq_pkg.sv =====
// ----------------------------------------------------------------------------
// adq_pkg: shared types and constants for the array deque
// Sizes, command codes, status codes and the item structs on both channels.
// ----------------------------------------------------------------------------
package adq_pkg;

	localparam int DEPTH      = 128;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// fixed field widths of the channels
	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int STS_W = 2;
	localparam int CNT_W = 8;

	localparam logic [IDX_W-1:0] IDX_ZERO = '0;
	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_REVERSE    = 3'd5,
		OP_QUERY      = 3'd6
	} op_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic [STS_W-1:0]        status;
		logic signed [VAL_W-1:0] front_value;
		logic signed [VAL_W-1:0] back_value;
		logic [CNT_W-1:0]        count;
		logic                    is_empty;
	} out_item_t;

	typedef struct packed {
		op_t                   op;
		logic [DATA_WIDTH-1:0] value;
	} cmd_entry_t;

	// head of the command queue as seen by the back part
	typedef struct packed {
		logic       valid;
		cmd_entry_t entry;
	} cq_head_t;

endpackage

// ===== design/array_double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// array_double_ended_queue_unit: deque held in a fixed, non-circular array
// Front part decodes commands into a short queue; back part runs them on RAM.
// ----------------------------------------------------------------------------
// Use:
//   req channel (req_valid / req_stall / req) takes one command item per
//   handshake: push front, push back, pop front, pop back, clear, reverse or
//   query. rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   result item per command, in order: status, both end values, count and
//   the empty flag as they stand after the command.
//   Push, clear, query and pops that empty the queue or underflow finish
//   without a RAM read; other pops do one RAM read of the new ends (S_LOAD).
//   Reverse over n held items does floor(n/2) swaps, one at a time through
//   the single RAM write port (S_REV_RD, S_REV_W1, S_REV_W2).
//   The two-entry command queue takes new items while the back is busy or
//   a result waits in the output register; req_stall rises when it is full.
//   When rsp_stall is high the result is held and the back waits in its
//   final step, so nothing is dropped.
//   Reset empties the queue and both indices go to slot 0; RAM contents are
//   not cleared, since only written slots are ever read.
// ----------------------------------------------------------------------------
module array_double_ended_queue_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  adq_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output adq_pkg::out_item_t rsp
);

	import adq_pkg::*;

	cq_head_t cq;       // head of the command queue
	logic     cq_take;  // back consumes the head this cycle

	adq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cq        (cq),
		.cq_take   (cq_take)
	);

	adq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq        (cq),
		.cq_take   (cq_take),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== design/adq_ram.sv =====
// ----------------------------------------------------------------------------
// adq_ram: generic RAM, one write port, two registered read ports
// Read data holds while its read enable is low.
// ----------------------------------------------------------------------------
module adq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re_a,
	input  logic [$clog2(DEPTH)-1:0]         raddr_a,
	output logic [WIDTH-1:0]                 rdata_a,
	input  logic                             re_b,
	input  logic [$clog2(DEPTH)-1:0]         raddr_b,
	output logic [WIDTH-1:0]                 rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== design/adq_front.sv =====
// ----------------------------------------------------------------------------
// adq_front: command intake
// Decodes incoming items and holds them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module adq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  adq_pkg::in_item_t  req,
	output adq_pkg::cq_head_t  cq,
	input  logic               cq_take
);

	import adq_pkg::*;

	cmd_entry_t          fifo_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] fill_q;
	cmd_entry_t          dec;
	logic                push;
	logic                pop;

	// unused code 7 behaves as a query
	always_comb begin
		case (req.cmd)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK,
			OP_CLEAR, OP_REVERSE, OP_QUERY: dec.op = op_t'(req.cmd);
			default:                        dec.op = OP_QUERY;
		endcase
		dec.value = DATA_WIDTH'(unsigned'(req.push_value));
	end

	assign req_stall = (fill_q == CQ_CNT_W'(CQ_DEPTH));
	assign push      = req_valid && !req_stall;
	assign pop       = cq_take && cq.valid;

	assign cq.valid = (fill_q != '0);
	assign cq.entry = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== design/adq_back.sv =====
// ----------------------------------------------------------------------------
// adq_back: command execution
// Sequencer over the element RAM; caches both ends and registers the result.
// ----------------------------------------------------------------------------
module adq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  adq_pkg::cq_head_t  cq,
	output logic               cq_take,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output adq_pkg::out_item_t rsp
);

	import adq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOAD   = 6'b000010,
		S_REV_RD = 6'b000100,
		S_REV_W1 = 6'b001000,
		S_REV_W2 = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      head_q, head_d;
	logic [IDX_W-1:0]      tail_q, tail_d;
	logic                  empty_q, empty_d;
	logic [IDX_W-1:0]      i_q, i_d;
	logic [IDX_W-1:0]      j_q, j_d;
	logic [DATA_WIDTH-1:0] front_q, front_d;
	logic [DATA_WIDTH-1:0] back_q, back_d;
	status_t               status_q, status_d;
	logic                  rsp_valid_q;
	out_item_t             rsp_q;
	out_item_t             res;
	logic                  rsp_load;
	logic [IDX_W:0]        span;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr_a;
	logic [IDX_W-1:0]      ram_raddr_b;
	logic [DATA_WIDTH-1:0] ram_rdata_a;
	logic [DATA_WIDTH-1:0] ram_rdata_b;

	adq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re_a    (ram_re),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.re_b    (ram_re),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	assign cq_take  = (state_q == S_IDLE) && cq.valid;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		empty_d     = empty_q;
		i_d         = i_q;
		j_d         = j_q;
		front_d     = front_q;
		back_d      = back_q;
		status_d    = status_q;
		ram_we      = 1'b0;
		ram_waddr   = i_q;
		ram_wdata   = cq.entry.value;
		ram_re      = 1'b0;
		ram_raddr_a = i_q;
		ram_raddr_b = j_q;

		case (state_q)
			S_IDLE: begin
				if (cq.valid) begin
					status_d = ST_OK;
					state_d  = S_DONE;
					case (cq.entry.op)
						OP_PUSH_FRONT: begin
							if (empty_q) begin
								empty_d   = 1'b0;
								ram_we    = 1'b1;
								ram_waddr = IDX_ZERO;
								front_d   = cq.entry.value;
								back_d    = cq.entry.value;
							end else if (head_q == IDX_ZERO) begin
								status_d = ST_OVERFLOW;
							end else begin
								head_d    = head_q - IDX_ONE;
								ram_we    = 1'b1;
								ram_waddr = head_q - IDX_ONE;
								front_d   = cq.entry.value;
							end
						end
						OP_PUSH_BACK: begin
							if (empty_q) begin
								empty_d   = 1'b0;
								ram_we    = 1'b1;
								ram_waddr = IDX_ZERO;
								front_d   = cq.entry.value;
								back_d    = cq.entry.value;
							end else if (tail_q == LAST_IDX) begin
								status_d = ST_OVERFLOW;
							end else begin
								tail_d    = tail_q + IDX_ONE;
								ram_we    = 1'b1;
								ram_waddr = tail_q + IDX_ONE;
								back_d    = cq.entry.value;
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (empty_q) begin
								status_d = ST_UNDERFLOW;
							end else if (head_q == tail_q) begin
								empty_d = 1'b1;
								head_d  = IDX_ZERO;
								tail_d  = IDX_ZERO;
							end else begin
								// fetch the new ends, load them next cycle
								ram_re  = 1'b1;
								state_d = S_LOAD;
								if (cq.entry.op == OP_POP_FRONT) begin
									head_d      = head_q + IDX_ONE;
									ram_raddr_a = head_q + IDX_ONE;
									ram_raddr_b = tail_q;
								end else begin
									tail_d      = tail_q - IDX_ONE;
									ram_raddr_a = head_q;
									ram_raddr_b = tail_q - IDX_ONE;
								end
							end
						end
						OP_CLEAR: begin
							empty_d = 1'b1;
							head_d  = IDX_ZERO;
							tail_d  = IDX_ZERO;
						end
						OP_REVERSE: begin
							if (!empty_q && (head_q != tail_q)) begin
								i_d     = head_q;
								j_d     = tail_q;
								front_d = back_q;
								back_d  = front_q;
								state_d = S_REV_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LOAD: begin
				front_d = ram_rdata_a;
				back_d  = ram_rdata_b;
				state_d = S_DONE;
			end
			S_REV_RD: begin
				ram_re  = 1'b1;
				state_d = S_REV_W1;
			end
			S_REV_W1: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata_b;
				state_d   = S_REV_W2;
			end
			S_REV_W2: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = ram_rdata_a;
				i_d       = i_q + IDX_ONE;
				j_d       = j_q - IDX_ONE;
				if ((i_q + IDX_ONE) < (j_q - IDX_ONE)) begin
					state_d = S_REV_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result view of the state after the command
	assign span = {1'b0, tail_q} - {1'b0, head_q} + {{IDX_W{1'b0}}, 1'b1};

	always_comb begin
		res.status = status_q;
		if (empty_q) begin
			res.front_value = '1;
			res.back_value  = '1;
			res.count       = '0;
			res.is_empty    = 1'b1;
		end else begin
			res.front_value = VAL_W'(front_q);
			res.back_value  = VAL_W'(back_q);
			res.count       = CNT_W'(span);
			res.is_empty    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			empty_q     <= empty_d;
			i_q         <= i_d;
			j_q         <= j_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		front_q  <= front_d;
		back_q   <= back_d;
		status_q <= status_d;
		if (rsp_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> head_q <= tail_q)
		else $error("head above tail while not empty");
	a_empty_home: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("indices not at slot 0 while empty");
	a_rev_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REV_RD) |-> (i_q < j_q))
		else $error("reverse pair crossed");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cq_take |=> (state_q != S_IDLE))
		else $error("sequencer idle right after taking a command");
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp_valid_q && (state_q == S_IDLE))
		else $error("result load did not present an item");
`endif

endmodule
